// ===== src/sldab_pkg.sv =====
// Shared types and constants for the spaced line dab stepper.
// Used by sldab_engine and spaced_line_dab_stepper_core; no dependencies.
package sldab_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int SPACING_WIDTH   = 12;
	localparam int DIST_WIDTH      = 13;
	localparam int CFG_INDEX_WIDTH = 1;
	localparam int CFG_DATA_WIDTH  = SPACING_WIDTH;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_DAB_SPACING    = 1'b0,
		REG_SPACING_ENABLE = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [SPACING_WIDTH-1:0] dab_spacing;
		logic                     spacing_enable;
	} spacing_cfg_t;

endpackage

// ===== src/sldab_engine.sv =====
// Line state and combinational Bresenham update for the dab stepper.
// Depends on sldab_pkg for the command codes and the spacing configuration.
module sldab_engine #(
	parameter int COORD_WIDTH = sldab_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                command,
	input  logic signed [COORD_WIDTH-1:0]       start_x,
	input  logic signed [COORD_WIDTH-1:0]       start_y,
	input  logic signed [COORD_WIDTH-1:0]       end_x,
	input  logic signed [COORD_WIDTH-1:0]       end_y,
	input  logic                                clear_distance,
	input  sldab_pkg::spacing_cfg_t             cfg,
	output logic                                dab_valid,
	output logic signed [COORD_WIDTH-1:0]       dab_x,
	output logic signed [COORD_WIDTH-1:0]       dab_y,
	output logic                                line_done
);

	localparam int W  = COORD_WIDTH;
	localparam int TW = COORD_WIDTH + 1;
	localparam int EW = COORD_WIDTH + 3;
	localparam int DW = sldab_pkg::DIST_WIDTH;

	logic [W-1:0]  pos_x_q, pos_y_q, tgt_x_q, tgt_y_q;
	logic [TW-1:0] tdx_q, tdy_q;
	logic          x_neg_q, y_neg_q, x_major_q;
	logic [EW-1:0] err_q;
	logic [DW-1:0] dist_q;

	logic [W-1:0]  pos_x_n, pos_y_n, tgt_x_n, tgt_y_n;
	logic [TW-1:0] tdx_n, tdy_n;
	logic          x_neg_n, y_neg_n, x_major_n;
	logic [EW-1:0] err_n;
	logic [DW-1:0] dist_n;
	logic          fire;

	logic [W:0]    dx, dy, adx_full, ady_full;
	logic [W-1:0]  adx, ady;
	logic [TW-1:0] tdx_l, tdy_l, tmaj, tmin;
	logic          xmaj_l, moving, e_ge, move_x, move_y;
	logic [EW-1:0] err_l, err_a;
	logic [DW-1:0] dist_inc;
	logic          is_step;

	assign is_step = (sldab_pkg::cmd_t'(command) == sldab_pkg::CMD_STEP);

	// Load setup terms.
	always_comb begin
		dx       = {end_x[W-1], end_x} - {start_x[W-1], start_x};
		dy       = {end_y[W-1], end_y} - {start_y[W-1], start_y};
		adx_full = dx[W] ? (~dx + (W+1)'(1)) : dx;
		ady_full = dy[W] ? (~dy + (W+1)'(1)) : dy;
		adx      = adx_full[W-1:0];
		ady      = ady_full[W-1:0];
		tdx_l    = {adx, 1'b0};
		tdy_l    = {ady, 1'b0};
		xmaj_l   = tdx_l > tdy_l;
		if (xmaj_l) begin
			err_l = {2'b00, tdy_l} - {3'b000, adx};
		end else begin
			err_l = {2'b00, tdx_l} - {3'b000, ady};
		end
	end

	// Step terms.
	always_comb begin
		moving   = x_major_q ? (pos_x_q != tgt_x_q) : (pos_y_q != tgt_y_q);
		e_ge     = !err_q[EW-1];
		tmaj     = x_major_q ? tdx_q : tdy_q;
		tmin     = x_major_q ? tdy_q : tdx_q;
		err_a    = e_ge ? (err_q - {2'b00, tmaj}) : err_q;
		move_x   = moving && (x_major_q || e_ge);
		move_y   = moving && (!x_major_q || e_ge);
		dist_inc = dist_q + DW'(1);
	end

	always_comb begin
		pos_x_n   = pos_x_q;
		pos_y_n   = pos_y_q;
		tgt_x_n   = tgt_x_q;
		tgt_y_n   = tgt_y_q;
		tdx_n     = tdx_q;
		tdy_n     = tdy_q;
		x_neg_n   = x_neg_q;
		y_neg_n   = y_neg_q;
		x_major_n = x_major_q;
		err_n     = err_q;
		dist_n    = dist_q;
		fire      = 1'b0;
		if (!is_step) begin
			pos_x_n   = start_x;
			pos_y_n   = start_y;
			tgt_x_n   = end_x;
			tgt_y_n   = end_y;
			tdx_n     = tdx_l;
			tdy_n     = tdy_l;
			x_neg_n   = dx[W];
			y_neg_n   = dy[W];
			x_major_n = xmaj_l;
			err_n     = err_l;
			if (clear_distance) begin
				dist_n = '0;
			end
		end else if (moving) begin
			if (move_x) begin
				pos_x_n = x_neg_q ? (pos_x_q - W'(1)) : (pos_x_q + W'(1));
			end
			if (move_y) begin
				pos_y_n = y_neg_q ? (pos_y_q - W'(1)) : (pos_y_q + W'(1));
			end
			err_n = err_a + {2'b00, tmin};
			if (cfg.spacing_enable) begin
				if (dist_inc > {1'b0, cfg.dab_spacing}) begin
					fire   = 1'b1;
					dist_n = '0;
				end else begin
					dist_n = dist_inc;
				end
			end else begin
				fire = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			tgt_x_q   <= '0;
			tgt_y_q   <= '0;
			tdx_q     <= '0;
			tdy_q     <= '0;
			x_neg_q   <= 1'b0;
			y_neg_q   <= 1'b0;
			x_major_q <= 1'b0;
			err_q     <= '0;
			dist_q    <= '0;
		end else if (en) begin
			pos_x_q   <= pos_x_n;
			pos_y_q   <= pos_y_n;
			tgt_x_q   <= tgt_x_n;
			tgt_y_q   <= tgt_y_n;
			tdx_q     <= tdx_n;
			tdy_q     <= tdy_n;
			x_neg_q   <= x_neg_n;
			y_neg_q   <= y_neg_n;
			x_major_q <= x_major_n;
			err_q     <= err_n;
			dist_q    <= dist_n;
		end
	end

	assign dab_valid = fire;
	assign dab_x     = pos_x_n;
	assign dab_y     = pos_y_n;
	assign line_done = (pos_x_n == tgt_x_n) && (pos_y_n == tgt_y_n);

`ifndef SYNTHESIS
	a_idle_step_holds: assert property (@(posedge clk) disable iff (!arst_n)
		en && is_step && !moving |=> $stable(pos_x_q) && $stable(pos_y_q) && $stable(dist_q))
		else $error("step past the end moved the pen or the counter");

	a_dist_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		dist_q <= DW'(4096))
		else $error("distance counter out of range");

	a_major_axis: assert property (@(posedge clk) disable iff (!arst_n)
		x_major_q |-> tdx_q > tdy_q)
		else $error("x taken as major axis without the larger delta");

	a_fire_needs_move: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> is_step && moving)
		else $error("dab fired without a step");
`endif

endmodule

// ===== src/spaced_line_dab_stepper_core.sv =====
// Top level of the spaced line dab stepper: handshakes, configuration registers
// and the input and result registers. Depends on sldab_pkg and sldab_engine.
//
// A load item (command 0) sets up a line from its start and end points and
// returns the start point with no dab. A step item (command 1) advances one
// pixel along the major axis and returns the new point; a dab is flagged on
// every step, or, with spacing enabled, when the running distance count passes
// dab_spacing. A step once the line end is reached returns the end point
// unchanged with no dab. line_done flags that the point equals the line end.
// Each item returns exactly one result item.
// Items enter on in_valid/in_ready into an input register; the update runs
// as the item advances and writes the output register and the line state.
// One item is taken per cycle while the output is not stalled; the line update
// loop (position, error term and distance counter) sets that rate.
// When out_ready is low the result waits, the input register still holds one
// further item, and in_ready falls only when both are full.
// Reset clears the line to a zero-length line at the origin, the distance count
// to zero, dab_spacing to zero and spacing_enable to one. Configuration writes
// take effect at once; the user makes them only while no item is in flight.
module spaced_line_dab_stepper_core #(
	parameter int COORD_WIDTH = sldab_pkg::COORD_WIDTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_we,
	input  logic [sldab_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
	input  logic [sldab_pkg::CFG_DATA_WIDTH-1:0]       cfg_wdata,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic                                       command,
	input  logic signed [COORD_WIDTH-1:0]              start_x,
	input  logic signed [COORD_WIDTH-1:0]              start_y,
	input  logic signed [COORD_WIDTH-1:0]              end_x,
	input  logic signed [COORD_WIDTH-1:0]              end_y,
	input  logic                                       clear_distance,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic                                       dab_valid,
	output logic signed [COORD_WIDTH-1:0]              dab_x,
	output logic signed [COORD_WIDTH-1:0]              dab_y,
	output logic                                       line_done
);

	sldab_pkg::spacing_cfg_t cfg_q;

	logic                   v_s1;
	logic                   command_s1;
	logic [COORD_WIDTH-1:0] start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	logic                   clear_s1;

	logic                   adv;
	logic                   r_dab_valid, r_line_done;
	logic [COORD_WIDTH-1:0] r_dab_x, r_dab_y;

	logic                   out_valid_q;
	logic                   dab_valid_q, line_done_q;
	logic [COORD_WIDTH-1:0] dab_x_q, dab_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dab_spacing    <= '0;
			cfg_q.spacing_enable <= 1'b1;
		end else if (cfg_we) begin
			unique case (sldab_pkg::reg_index_t'(cfg_index))
				sldab_pkg::REG_DAB_SPACING: cfg_q.dab_spacing <= cfg_wdata;
				sldab_pkg::REG_SPACING_ENABLE: cfg_q.spacing_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= command;
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			end_x_s1   <= end_x;
			end_y_s1   <= end_y;
			clear_s1   <= clear_distance;
		end
	end

	sldab_engine #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (adv),
		.command        (command_s1),
		.start_x        (start_x_s1),
		.start_y        (start_y_s1),
		.end_x          (end_x_s1),
		.end_y          (end_y_s1),
		.clear_distance (clear_s1),
		.cfg            (cfg_q),
		.dab_valid      (r_dab_valid),
		.dab_x          (r_dab_x),
		.dab_y          (r_dab_y),
		.line_done      (r_line_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dab_valid_q <= r_dab_valid;
			dab_x_q     <= r_dab_x;
			dab_y_q     <= r_dab_y;
			line_done_q <= r_line_done;
		end
	end

	assign out_valid = out_valid_q;
	assign dab_valid = dab_valid_q;
	assign dab_x     = dab_x_q;
	assign dab_y     = dab_y_q;
	assign line_done = line_done_q;

endmodule

// ===== tb/sv/spaced_line_dab_stepper_core_tb.sv =====
// Self-checking testbench for spaced_line_dab_stepper_core: a directed table of line items,
// then random line sequences under several spacing settings, each result checked in order
// against a line predictor or a typed row. Depends on sldab_pkg and the core RTL only.
module spaced_line_dab_stepper_core_tb;

	typedef logic signed [sldab_pkg::COORD_WIDTH_DEF-1:0] coord_t;

	typedef struct packed {
		logic   dab;
		coord_t x;
		coord_t y;
		logic   done;
	} dab_result_t;

	typedef struct {
		sldab_pkg::cmd_t cmd;
		coord_t          sx;
		coord_t          sy;
		coord_t          ex;
		coord_t          ey;
		logic            clr;
		logic            typed;
		dab_result_t     want;
	} stim_row_t;

	localparam sldab_pkg::cmd_t LD = sldab_pkg::CMD_LOAD;
	localparam sldab_pkg::cmd_t ST = sldab_pkg::CMD_STEP;
	localparam dab_result_t UNTYPED = '0;
	localparam coord_t C_MIN = 16'sh8000;
	localparam coord_t C_MAX = 16'sh7FFF;

	logic                                  clk;
	logic                                  arst_n = 1'b0;
	logic                                  cfg_we = 1'b0;
	logic [sldab_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = sldab_pkg::REG_DAB_SPACING;
	logic [sldab_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;
	logic                                  in_valid = 1'b0;
	logic                                  in_ready;
	logic                                  command = LD;
	coord_t                                start_x = '0;
	coord_t                                start_y = '0;
	coord_t                                end_x = '0;
	coord_t                                end_y = '0;
	logic                                  clear_distance = 1'b0;
	logic                                  out_valid;
	logic                                  out_ready = 1'b0;
	logic                                  dab_valid;
	coord_t                                dab_x;
	coord_t                                dab_y;
	logic                                  line_done;

	logic        row_typed = 1'b0;
	dab_result_t row_want = '0;

	int unsigned send_idle = 27;
	int unsigned recv_idle = 47;
	int unsigned items_sent = 0;
	int unsigned mismatches = 0;
	dab_result_t pending_dabs [$];

	// Predictor state, as after reset.
	coord_t                              pos_x = '0;
	coord_t                              pos_y = '0;
	coord_t                              tgt_x = '0;
	coord_t                              tgt_y = '0;
	logic [17:0]                         dbl_dx = '0;
	logic [17:0]                         dbl_dy = '0;
	logic                                neg_x = 1'b0;
	logic                                neg_y = 1'b0;
	logic                                major_x = 1'b0;
	logic signed [18:0]                  err = '0;
	logic [sldab_pkg::DIST_WIDTH-1:0]    dist_cnt = '0;
	logic [sldab_pkg::SPACING_WIDTH-1:0] spacing_now = '0;
	logic                                spacing_on = 1'b1;

	stim_row_t dir_table [21] = '{
		'{ST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, '{1'b0, 16'sd0, 16'sd0, 1'b1}},
		'{LD, C_MIN, C_MIN, C_MAX, C_MAX, 1'b1, 1'b1, '{1'b0, C_MIN, C_MIN, 1'b0}},
		'{ST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, UNTYPED},
		'{ST, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, UNTYPED},
		'{LD, C_MAX, C_MIN, C_MIN, C_MAX, 1'b0, 1'b1, '{1'b0, C_MAX, C_MIN, 1'b0}},
		'{ST, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, UNTYPED},
		'{LD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, '{1'b0, 16'sd0, 16'sd0, 1'b1}},
		'{ST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, '{1'b0, 16'sd0, 16'sd0, 1'b1}},
		'{LD, 16'sh7FFC, C_MIN, C_MAX, 16'sh8001, 1'b1, 1'b1,
			'{1'b0, 16'sh7FFC, C_MIN, 1'b0}},
		'{ST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, UNTYPED},
		'{ST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, UNTYPED},
		'{ST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, UNTYPED},
		'{ST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, '{1'b0, C_MAX, 16'sh8001, 1'b1}},
		'{LD, 16'sd5, 16'sd5, -16'sd2, 16'sd1, 1'b0, 1'b0, UNTYPED},
		'{ST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, UNTYPED},
		'{ST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, UNTYPED},
		'{LD, 16'sd10, -16'sd3, 16'sd10, 16'sd4, 1'b1, 1'b0, UNTYPED},
		'{ST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, UNTYPED},
		'{LD, 16'sd0, 16'sd0, 16'sd3, -16'sd3, 1'b0, 1'b0, UNTYPED},
		'{ST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, UNTYPED},
		'{ST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, UNTYPED}
	};

	int unsigned phase_spacing [6] = '{1, 0, 3, 0, 400, 4095};
	logic        phase_enable [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

	spaced_line_dab_stepper_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.clear_distance(clear_distance),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.dab_valid     (dab_valid),
		.dab_x         (dab_x),
		.dab_y         (dab_y),
		.line_done     (line_done)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic dab_result_t advance_line(sldab_pkg::cmd_t cmd, coord_t sx, coord_t sy,
			coord_t ex, coord_t ey, logic clr);
		int dx;
		int dy;
		int e;
		dab_result_t r;
		r.dab = 1'b0;
		if (cmd == sldab_pkg::CMD_LOAD) begin
			pos_x = sx;
			pos_y = sy;
			tgt_x = ex;
			tgt_y = ey;
			dx = int'(ex) - int'(sx);
			dy = int'(ey) - int'(sy);
			neg_x = dx < 0;
			neg_y = dy < 0;
			if (neg_x) dx = -dx;
			if (neg_y) dy = -dy;
			dbl_dx = 18'(2 * dx);
			dbl_dy = 18'(2 * dy);
			major_x = dx > dy;
			err = major_x ? 19'(2 * dy - dx) : 19'(2 * dx - dy);
			if (clr) dist_cnt = '0;
		end else if (major_x ? (pos_x != tgt_x) : (pos_y != tgt_y)) begin
			e = int'(err);
			if (major_x) begin
				if (e >= 0) begin
					pos_y = neg_y ? pos_y - 16'sd1 : pos_y + 16'sd1;
					e = e - int'(dbl_dx);
				end
				pos_x = neg_x ? pos_x - 16'sd1 : pos_x + 16'sd1;
				e = e + int'(dbl_dy);
			end else begin
				if (e >= 0) begin
					pos_x = neg_x ? pos_x - 16'sd1 : pos_x + 16'sd1;
					e = e - int'(dbl_dy);
				end
				pos_y = neg_y ? pos_y - 16'sd1 : pos_y + 16'sd1;
				e = e + int'(dbl_dx);
			end
			err = 19'(e);
			if (spacing_on) begin
				dist_cnt = dist_cnt + 1'b1;
				if (dist_cnt > {1'b0, spacing_now}) begin
					r.dab = 1'b1;
					dist_cnt = '0;
				end
			end else begin
				r.dab = 1'b1;
			end
		end
		r.x = pos_x;
		r.y = pos_y;
		r.done = (pos_x == tgt_x) && (pos_y == tgt_y);
		return r;
	endfunction

	task automatic note_mismatch(string field, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d", field, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		dab_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_dabs.size() == 0) begin
					note_mismatch("result with no item pending, dab_x", dab_x, 0);
				end else begin
					want = pending_dabs.pop_front();
					if (dab_valid !== want.dab) note_mismatch("dab_valid", dab_valid, want.dab);
					if (dab_x !== want.x) note_mismatch("dab_x", dab_x, want.x);
					if (dab_y !== want.y) note_mismatch("dab_y", dab_y, want.y);
					if (line_done !== want.done) note_mismatch("line_done", line_done, want.done);
				end
			end
			if (in_valid && in_ready) begin
				want = advance_line(sldab_pkg::cmd_t'(command), start_x, start_y, end_x, end_y,
					clear_distance);
				pending_dabs.push_back(row_typed ? row_want : want);
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_item(sldab_pkg::cmd_t cmd, coord_t sx, coord_t sy, coord_t ex,
			coord_t ey, logic clr, logic typed, dab_result_t want);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		command        <= cmd;
		start_x        <= sx;
		start_y        <= sy;
		end_x          <= ex;
		end_y          <= ey;
		clear_distance <= clr;
		row_typed      <= typed;
		row_want       <= want;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_dabs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(sldab_pkg::reg_index_t idx,
			logic [sldab_pkg::CFG_DATA_WIDTH-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			sldab_pkg::REG_DAB_SPACING: spacing_now = val[sldab_pkg::SPACING_WIDTH-1:0];
			sldab_pkg::REG_SPACING_ENABLE: spacing_on = val[0];
			default: ;
		endcase
	endtask

	// Mostly whole lines walked to their end and a little past it, with
	// some lines cut short, some random loads and some stray step bursts.
	task automatic run_random(int unsigned count);
		int unsigned goal;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		int span;
		int ax;
		int ay;
		int steps;
		int kind;
		goal = items_sent + count;
		while (items_sent < goal) begin
			kind = $urandom_range(99);
			sx = coord_t'($urandom);
			sy = coord_t'($urandom);
			ex = coord_t'($urandom);
			ey = coord_t'($urandom);
			if (kind < 80) begin
				span = ($urandom_range(9) == 0) ? 300 : 24;
				ex = coord_t'(int'(sx) + int'($urandom_range(2 * span)) - span);
				ey = coord_t'(int'(sy) + int'($urandom_range(2 * span)) - span);
				ax = int'(ex) - int'(sx);
				ay = int'(ey) - int'(sy);
				if (ax < 0) ax = -ax;
				if (ay < 0) ay = -ay;
				steps = (ax > ay ? ax : ay) + int'($urandom_range(3));
				if (steps > 320) steps = 320;
				if ($urandom_range(9) == 0) steps = int'($urandom_range(steps));
			end else if (kind < 92) begin
				steps = int'($urandom_range(5));
			end else begin
				steps = int'($urandom_range(1, 4));
			end
			if (kind < 92) send_item(LD, sx, sy, ex, ey, 1'($urandom), 1'b0, UNTYPED);
			repeat (steps) begin
				send_item(ST, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), 1'($urandom), 1'b0, UNTYPED);
			end
			if ($urandom_range(49) == 0) drain_results();
		end
	endtask

	initial begin
		int unsigned spacing;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_table[i]) begin
			send_item(dir_table[i].cmd, dir_table[i].sx, dir_table[i].sy, dir_table[i].ex,
				dir_table[i].ey, dir_table[i].clr, dir_table[i].typed, dir_table[i].want);
		end
		for (int p = 0; p < 6; p++) begin
			drain_results();
			send_idle = (p < 2) ? 27 : (p < 4) ? 47 : 0;
			recv_idle = (p < 2) ? 47 : (p < 4) ? 27 : 0;
			spacing = (p == 3) ? $urandom_range(2, 40) : phase_spacing[p];
			write_reg(sldab_pkg::REG_DAB_SPACING, sldab_pkg::CFG_DATA_WIDTH'(spacing));
			write_reg(sldab_pkg::REG_SPACING_ENABLE,
				sldab_pkg::CFG_DATA_WIDTH'(phase_enable[p]));
			if (p == 4) begin
				// Long enough for the distance count to pass the spacing.
				send_item(LD, -16'sd250, 16'sd7, 16'sd250, -16'sd30, 1'b1, 1'b0, UNTYPED);
				repeat (505) send_item(ST, '0, '0, '0, '0, 1'b0, 1'b0, UNTYPED);
			end
			run_random(250);
		end
		drain_results();
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
